/* rtl/direction_angles_from_points_unit_macros.svh */
`ifndef DIRECTION_ANGLES_FROM_POINTS_UNIT_MACROS_SVH
`define DIRECTION_ANGLES_FROM_POINTS_UNIT_MACROS_SVH

// same-cycle implication on the unit clock, off during reset
`define DAFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dafp assertion failed");

// next-cycle implication on the unit clock, off during reset
`define DAFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dafp assertion failed");

`endif

/* rtl/dafp_pkg.sv */
package dafp_pkg;

   localparam int CORDIC_STAGES = 20;
   localparam int STAGE_COUNT   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int STAGE_IDX_W   = 5;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = 33;
   localparam int GUARD_BITS = 8;
   localparam int VEC_W      = 44;
   localparam int ANG_W      = 34;
   localparam int YAW_W      = 25;
   localparam int PITCH_W    = 24;
   localparam int ROUND_BITS = 8;

   localparam int GAIN_W  = 30;
   localparam int SPLIT_W = 21;
   localparam int HI_W    = VEC_W - 1 - SPLIT_W;
   localparam int PROD_W  = HI_W + GAIN_W + SPLIT_W;

   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

   localparam logic signed [ANG_W-1:0] DEG90       = 34'sd1509949440;
   localparam logic signed [ANG_W-1:0] YAW_LIMIT   = 34'sd11796480;
   localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 34'sd5898240;

   // atan(2^-i) in degrees, 24 fraction bits
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115,
      32'd57,        32'd29,        32'd14,        32'd7,
      32'd4,         32'd2,         32'd1,         32'd0
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] dz;
      logic signed [YAW_W-1:0] yaw;
      logic                    same;
      logic                    flat;
   } dafp_side_type;

   typedef struct packed {
      logic                    valid;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      dafp_side_type           side;
   } dafp_vec_type;

   function automatic logic signed [ANG_W-1:0] round_acc(input logic signed [ANG_W-1:0] acc);
      logic signed [ANG_W-1:0] sum;
      sum = acc + ANG_W'(1 << (ROUND_BITS - 1));
      return sum >>> ROUND_BITS;
   endfunction

   function automatic logic signed [ANG_W-1:0] clamp_sym(input logic signed [ANG_W-1:0] v,
                                                          input logic signed [ANG_W-1:0] lim);
      logic signed [ANG_W-1:0] r;
      r = v;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

/* rtl/dafp_if.sv */
interface dafp_req_if;
   import dafp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic signed [COORD_W-1:0] origin_z;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic signed [COORD_W-1:0] target_z;

   modport source (output valid, output origin_x, output origin_y, output origin_z,
                   output target_x, output target_y, output target_z, input ready);
   modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                   input target_x, input target_y, input target_z, output ready);
endinterface

interface dafp_rsp_if;
   import dafp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [YAW_W-1:0]   yaw_deg;
   logic signed [PITCH_W-1:0] pitch_deg;
   logic                      same_point;

   modport source (output valid, output yaw_deg, output pitch_deg, output same_point,
                   input ready);
   modport sink   (input valid, input yaw_deg, input pitch_deg, input same_point,
                   output ready);
endinterface

/* rtl/dafp_cell.sv */
module dafp_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [dafp_pkg::STAGE_IDX_W-1:0] stage,
   input  dafp_pkg::dafp_vec_type         prev,
   output dafp_pkg::dafp_vec_type         vec_ff
);
   import dafp_pkg::*;

   logic signed [VEC_W-1:0] sx;
   logic signed [VEC_W-1:0] sy;
   logic signed [ANG_W-1:0] step_angle;
   dafp_vec_type            vec_in;

   always_comb begin
      sx         = prev.x >>> stage;
      sy         = prev.y >>> stage;
      step_angle = ANG_W'(ATAN_TABLE[stage]);
      vec_in     = prev;
      // rotate toward the x axis
      if (!prev.y[VEC_W-1]) begin
         vec_in.x = prev.x + sy;
         vec_in.y = prev.y - sx;
         vec_in.z = prev.z + step_angle;
      end else begin
         vec_in.x = prev.x - sy;
         vec_in.y = prev.y + sx;
         vec_in.z = prev.z - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (advance) begin
         vec_ff <= vec_in;
      end
   end

endmodule

/* rtl/dafp_gain.sv */
module dafp_gain (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  dafp_pkg::dafp_vec_type prev,
   output dafp_pkg::dafp_vec_type vec_ff
);
   import dafp_pkg::*;

   logic                       a_valid_ff;
   logic [HI_W+GAIN_W-1:0]     prod_hi_ff;
   logic [HI_W+GAIN_W-1:0]     prod_hi_in;
   logic [SPLIT_W+GAIN_W-1:0]  prod_lo_ff;
   logic [SPLIT_W+GAIN_W-1:0]  prod_lo_in;
   dafp_side_type              side_ff;
   dafp_side_type              side_in;
   logic [PROD_W-1:0]          total;
   dafp_vec_type               vec_in;

   // split magnitude times inverse gain, finish yaw
   always_comb begin
      prod_hi_in = (HI_W+GAIN_W)'(prev.x[VEC_W-2:SPLIT_W]) * (HI_W+GAIN_W)'(INV_GAIN);
      prod_lo_in = (SPLIT_W+GAIN_W)'(prev.x[SPLIT_W-1:0]) * (SPLIT_W+GAIN_W)'(INV_GAIN);
      side_in    = prev.side;
      if (prev.side.flat) begin
         side_in.yaw = '0;
      end else begin
         side_in.yaw = YAW_W'(clamp_sym(round_acc(prev.z), YAW_LIMIT));
      end
   end

   // add partial products, seed the pitch rotation
   always_comb begin
      total        = (PROD_W'(prod_hi_ff) << SPLIT_W) + PROD_W'(prod_lo_ff);
      vec_in.valid = a_valid_ff;
      vec_in.x     = side_ff.flat ? '0 : VEC_W'(total[PROD_W-1:GAIN_W]);
      vec_in.y     = side_ff.dz;
      vec_in.z     = '0;
      vec_in.side  = side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= prev.valid;
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
         side_ff    <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (advance) begin
         vec_ff <= vec_in;
      end
   end

endmodule

/* rtl/direction_angles_from_points_unit.sv */
// Direction angles from an origin point to a target point.
// req channel: one beat carries origin and target, signed Q16.16 coordinates.
// rsp channel: one beat carries yaw_deg = atan2(dy, dx) and pitch_deg =
//   -atan2(dz, horizontal distance), both degrees times 65536, plus same_point,
//   set when the points coincide (both angles are then zero).
// Each beat makes exactly one rsp beat, in order.
// Pipeline: difference and quadrant prep, a row of yaw CORDIC cells, two
//   inverse-gain multiply stages, a row of pitch CORDIC cells, output register.
// Throughput: one beat per cycle while the output is not stalled; every
//   CORDIC iteration is its own cell.
// Stall: while the output register holds a beat the receiver has not taken,
//   the whole row holds and req.ready is low; it rises in the cycle the beat
//   is taken or the output register is empty.
// Reset: synchronous; clears all valid bits and holds req.ready low, the row
//   is empty afterwards and req.ready is high from the first cycle.
module direction_angles_from_points_unit (
   input logic         clock,
   input logic         reset,
   dafp_req_if.sink    req,
   dafp_rsp_if.source  rsp
);
   import dafp_pkg::*;
   `include "direction_angles_from_points_unit_macros.svh"

   logic                      advance;
   logic signed [DIFF_W-1:0]  dx;
   logic signed [DIFF_W-1:0]  dy;
   logic signed [DIFF_W-1:0]  dz;
   logic signed [VEC_W-1:0]   gx;
   logic signed [VEC_W-1:0]   gy;
   dafp_vec_type              prep_in;
   dafp_vec_type              prep_ff;
   dafp_vec_type              yaw_vec   [STAGE_COUNT+1];
   dafp_vec_type              pitch_vec [STAGE_COUNT+1];
   logic signed [ANG_W-1:0]   pitch_val;
   logic                      rsp_valid_ff;
   logic signed [YAW_W-1:0]   yaw_deg_ff;
   logic signed [PITCH_W-1:0] pitch_deg_ff;
   logic signed [PITCH_W-1:0] pitch_deg_in;
   logic                      same_point_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance && !reset;

   // differences, guard bits, fold the left half plane
   always_comb begin
      dx = DIFF_W'(req.target_x) - DIFF_W'(req.origin_x);
      dy = DIFF_W'(req.target_y) - DIFF_W'(req.origin_y);
      dz = DIFF_W'(req.target_z) - DIFF_W'(req.origin_z);
      gx = VEC_W'(dx) <<< GUARD_BITS;
      gy = VEC_W'(dy) <<< GUARD_BITS;
      prep_in.valid     = req.valid;
      prep_in.x         = gx;
      prep_in.y         = gy;
      prep_in.z         = '0;
      prep_in.side.dz   = VEC_W'(dz) <<< GUARD_BITS;
      prep_in.side.yaw  = '0;
      prep_in.side.flat = (dx == '0) && (dy == '0);
      prep_in.side.same = (dx == '0) && (dy == '0) && (dz == '0);
      if (gx[VEC_W-1]) begin
         if (!gy[VEC_W-1]) begin
            prep_in.x = gy;
            prep_in.y = -gx;
            prep_in.z = DEG90;
         end else begin
            prep_in.x = -gy;
            prep_in.y = gx;
            prep_in.z = -DEG90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign yaw_vec[0] = prep_ff;

   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_yaw
      dafp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .stage   (STAGE_IDX_W'(i)),
         .prev    (yaw_vec[i]),
         .vec_ff  (yaw_vec[i+1])
      );
   end

   dafp_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .prev    (yaw_vec[STAGE_COUNT]),
      .vec_ff  (pitch_vec[0])
   );

   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_pitch
      dafp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .stage   (STAGE_IDX_W'(i)),
         .prev    (pitch_vec[i]),
         .vec_ff  (pitch_vec[i+1])
      );
   end

   always_comb begin
      pitch_val = clamp_sym(-round_acc(pitch_vec[STAGE_COUNT].z), PITCH_LIMIT);
      if (pitch_vec[STAGE_COUNT].side.same) begin
         pitch_deg_in = '0;
      end else begin
         pitch_deg_in = PITCH_W'(pitch_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= pitch_vec[STAGE_COUNT].valid;
         yaw_deg_ff    <= pitch_vec[STAGE_COUNT].side.yaw;
         pitch_deg_ff  <= pitch_deg_in;
         same_point_ff <= pitch_vec[STAGE_COUNT].side.same;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.yaw_deg    = yaw_deg_ff;
   assign rsp.pitch_deg  = pitch_deg_ff;
   assign rsp.same_point = same_point_ff;

   `DAFP_ASSERT_NOW(a_same_zero, rsp.valid && rsp.same_point,
      rsp.yaw_deg == '0 && rsp.pitch_deg == '0)
   `DAFP_ASSERT_NOW(a_yaw_range, rsp.valid,
      ANG_W'(rsp.yaw_deg) <= YAW_LIMIT && ANG_W'(rsp.yaw_deg) >= -YAW_LIMIT)
   `DAFP_ASSERT_NOW(a_pitch_range, rsp.valid,
      ANG_W'(rsp.pitch_deg) <= PITCH_LIMIT && ANG_W'(rsp.pitch_deg) >= -PITCH_LIMIT)
   `DAFP_ASSERT_NOW(a_stall_full, !req.ready, rsp.valid && !rsp.ready)
   `DAFP_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, prep_ff.valid)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import dafp_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic signed [COORD_W-1:0] oz;
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
      logic signed [COORD_W-1:0] tz;
   } point_pair_type;

   typedef struct {
      logic signed [YAW_W-1:0]   yaw;
      logic signed [PITCH_W-1:0] pitch;
      logic                      same;
   } angles_type;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 2 * STAGE_COUNT + 24;
   localparam longint LIMIT_NS = 64'd20_000_000;

   logic clock;
   logic reset;

   dafp_req_if req_bus ();
   dafp_rsp_if rsp_bus ();

   direction_angles_from_points_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   angles_type angles_due[$];
   int      mismatch_count = 0;
   bit      calm = 0;
   int      hold_asked = 0;
   int      hold_seen = 0;
   int      stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("** direction_angles_from_points_unit: FAILED **");
      $finish;
   end

   function automatic longint cordic_turn(input longint x0, input longint y0,
                                          output longint mag);
      longint x, y, z, sx, sy;
      int i;
      x = x0;
      y = y0;
      z = 0;
      for (i = 0; i < STAGE_COUNT; i++) begin
         sy = y >>> i;
         sx = x >>> i;
         if (y >= 0) begin
            x = x + sy;
            y = y - sx;
            z = z + longint'(ATAN_TABLE[i]);
         end else begin
            x = x - sy;
            y = y + sx;
            z = z - longint'(ATAN_TABLE[i]);
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic longint round_clamp(input longint acc, input longint lim, input bit negate);
      longint r;
      r = (acc + (longint'(1) << (ROUND_BITS - 1))) >>> ROUND_BITS;
      if (negate) begin
         r = -r;
      end
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   function automatic angles_type predict_angles(input point_pair_type p);
      angles_type   r;
      longint       dx, dy, dz, x, y, t, base, mag, h, acc, yaw_v, pitch_v;
      logic [95:0]  prod;
      bit           same;
      dx = longint'(p.tx) - longint'(p.ox);
      dy = longint'(p.ty) - longint'(p.oy);
      dz = longint'(p.tz) - longint'(p.oz);
      same = (dx == 0) && (dy == 0) && (dz == 0);
      yaw_v = 0;
      pitch_v = 0;
      h = 0;
      if (dx != 0 || dy != 0) begin
         x = dx <<< GUARD_BITS;
         y = dy <<< GUARD_BITS;
         base = 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;
               y = -t;
               base = longint'(DEG90);
            end else begin
               x = -y;
               y = t;
               base = -longint'(DEG90);
            end
         end
         acc = base + cordic_turn(x, y, mag);
         yaw_v = round_clamp(acc, longint'(YAW_LIMIT), 1'b0);
         prod = 96'(mag) * 96'(INV_GAIN);
         h = longint'(prod >> GAIN_W);
      end
      if (!same) begin
         acc = cordic_turn(h, dz <<< GUARD_BITS, mag);
         pitch_v = round_clamp(acc, longint'(PITCH_LIMIT), 1'b1);
      end
      r.yaw = yaw_v[YAW_W-1:0];
      r.pitch = pitch_v[PITCH_W-1:0];
      r.same = same;
      return r;
   endfunction

   function automatic point_pair_type make_pair(input logic signed [COORD_W-1:0] ox, oy, oz,
                                                input logic signed [COORD_W-1:0] tx, ty, tz);
      point_pair_type p;
      p.ox = ox;
      p.oy = oy;
      p.oz = oz;
      p.tx = tx;
      p.ty = ty;
      p.tz = tz;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   function automatic int small_delta();
      int span;
      span = 1 << $urandom_range(0, 20);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [COORD_W-1:0] corner_coord();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type p;
      int r;
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return p;
      end else if (r < 70) begin
         p.tx = p.ox + small_delta();
         p.ty = p.oy + small_delta();
         p.tz = p.oz + small_delta();
      end else if (r < 78) begin
         p.tx = p.ox;
         p.ty = p.oy;
         p.tz = p.oz;
      end else if (r < 84) begin
         p.tx = p.ox;
         p.ty = p.oy;
      end else if (r < 90) begin
         if ($urandom_range(0, 1)) begin
            p.tx = p.ox;
         end else begin
            p.ty = p.oy;
         end
         if ($urandom_range(0, 1)) begin
            p.tz = p.oz;
         end
      end else if (r < 95) begin
         p = make_pair(corner_coord(), corner_coord(), corner_coord(),
                       corner_coord(), corner_coord(), corner_coord());
      end else begin
         p.tx = p.ox - COORD_W'($urandom_range(1, 32'h7FFF_FFFF));
         p.ty = p.oy + ($urandom_range(0, 1) ? small_delta() : 0);
      end
      return p;
   endfunction

   task automatic send_pair(input point_pair_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.origin_x <= p.ox;
      req_bus.origin_y <= p.oy;
      req_bus.origin_z <= p.oz;
      req_bus.target_x <= p.tx;
      req_bus.target_y <= p.ty;
      req_bus.target_z <= p.tz;
      do @(posedge clock); while (!req_bus.ready);
      angles_due.push_back(predict_angles(p));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_same_point();
      point_pair_type p;
      send_pair(make_pair(0, 0, 0, 0, 0, 0));
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      p = make_pair($urandom, $urandom, $urandom, 0, 0, 0);
      p.tx = p.ox;
      p.ty = p.oy;
      p.tz = p.oz;
      send_pair(p);
   endtask

   task automatic test_vertical();
      send_pair(make_pair(0, 0, 0, 0, 0, 1));
      send_pair(make_pair(0, 0, 0, 0, 0, -1));
      send_pair(make_pair(5, -7, COORD_MIN, 5, -7, COORD_MAX));
      send_pair(make_pair(-3, 9, COORD_MAX, -3, 9, COORD_MIN));
   endtask

   task automatic test_plane_axes();
      send_pair(make_pair(0, 0, 0, 1, 0, 0));
      send_pair(make_pair(0, 0, 0, -1, 0, 0));
      send_pair(make_pair(0, 0, 0, 0, 1, 0));
      send_pair(make_pair(0, 0, 0, 0, -1, 0));
   endtask

   task automatic test_left_half();
      send_pair(make_pair(COORD_MAX, 0, 0, COORD_MIN, 0, 0));
      send_pair(make_pair(COORD_MAX, 0, 0, COORD_MIN, 1, 0));
      send_pair(make_pair(COORD_MAX, 0, 0, COORD_MIN, -1, 0));
      send_pair(make_pair(0, 0, 0, -32'sd65536, 32'sd1, 32'sd0));
   endtask

   task automatic test_extremes();
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(make_pair(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0));
      send_pair(make_pair(0, 0, COORD_MIN, 1, 0, COORD_MAX));
   endtask

   task automatic test_diagonals();
      send_pair(make_pair(0, 0, 0, 1, 1, 1));
      send_pair(make_pair(0, 0, 0, -1, -1, -1));
      send_pair(make_pair(0, 0, 0, 1, -1, 0));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_pair(random_pair());
   endtask

   task automatic test_input_stall();
      calm = 1'b1;
      hold_asked <= hold_asked + 1;
      repeat (150) send_pair(random_pair());
      calm = 1'b0;
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         repeat (15) send_pair(random_pair());
         wait_drained();
      end
   endtask

   task automatic test_steady_stream();
      calm = 1'b1;
      repeat (100) send_pair(random_pair());
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen <= hold_asked;
         stall_left <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left <= pick_stall() - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_beat
      angles_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (angles_due.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("rsp beat with nothing expected: yaw %0d pitch %0d same %0b",
                        rsp_bus.yaw_deg, rsp_bus.pitch_deg, rsp_bus.same_point);
            end
            mismatch_count++;
         end else begin
            want = angles_due.pop_front();
            if (rsp_bus.yaw_deg !== want.yaw || rsp_bus.pitch_deg !== want.pitch ||
                rsp_bus.same_point !== want.same) begin
               if (mismatch_count < 10) begin
                  $display("exp yaw %0d pitch %0d same %0b / act yaw %0d pitch %0d same %0b",
                           want.yaw, want.pitch, want.same,
                           rsp_bus.yaw_deg, rsp_bus.pitch_deg, rsp_bus.same_point);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.origin_x <= '0;
      req_bus.origin_y <= '0;
      req_bus.origin_z <= '0;
      req_bus.target_x <= '0;
      req_bus.target_y <= '0;
      req_bus.target_z <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_same_point();
      test_vertical();
      test_plane_axes();
      test_left_half();
      test_extremes();
      test_diagonals();
      test_random_mix(400);
      test_input_stall();
      test_random_mix(300);
      test_drain_pause();
      test_steady_stream();
      test_random_mix(250);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** direction_angles_from_points_unit: PASSED **");
      end else begin
         $display("** direction_angles_from_points_unit: FAILED **");
      end
      $finish;
   end

endmodule
